FILE: rtl/core/bcc_pkg.sv
// Shared types, codes and defaults for the button multi-click classifier.
`timescale 1ns / 1ps

package bcc_pkg;

   // Default tick counter width
   localparam int TICK_WIDTH_DEF = 16;

   // Register file geometry
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register reset values
   localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd200;
   localparam logic [15:0] GAP_RST           = 16'd200;
   localparam logic [7:0]  LONG_PRESS_RST    = 8'd2;

   // Register indexes (word address)
   typedef enum logic [1:0] {
      REG_SAMPLE_PERIOD = 2'd0,
      REG_GAP           = 2'd1,
      REG_LONG_PRESS    = 2'd2
   } reg_index_type;

   // Gesture phases
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_PRESS1 = 3'd1,
      PH_GAP1   = 3'd2,
      PH_PRESS2 = 3'd3,
      PH_GAP2   = 3'd4,
      PH_HOLD   = 3'd5
   } phase_type;

   // Result codes
   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_SINGLE = 3'd1,
      KIND_LONG   = 3'd2,
      KIND_DOUBLE = 3'd3,
      KIND_TRIPLE = 3'd4
   } kind_type;

   // Configuration handed from the register file to the classifier
   typedef struct packed {
      logic [15:0] sample_period_ticks;
      logic [15:0] gap_ticks;
      logic [7:0]  long_press_samples;
   } cfg_type;

endpackage

FILE: rtl/core/bcc_csr.sv
// APB-style configuration registers of the classifier.
`timescale 1ns / 1ps

module bcc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bcc_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [bcc_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [bcc_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready,
   output bcc_pkg::cfg_type                    cfg
);

   bcc_pkg::cfg_type cfg_ff;
   bcc_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [1:0]       reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[3:2];

   // Decode the write beat
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            bcc_pkg::REG_SAMPLE_PERIOD: cfg_in.sample_period_ticks = pwdata[15:0];
            bcc_pkg::REG_GAP:           cfg_in.gap_ticks = pwdata[15:0];
            bcc_pkg::REG_LONG_PRESS:    cfg_in.long_press_samples = pwdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_period_ticks <= bcc_pkg::SAMPLE_PERIOD_RST;
         cfg_ff.gap_ticks           <= bcc_pkg::GAP_RST;
         cfg_ff.long_press_samples  <= bcc_pkg::LONG_PRESS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      case (reg_sel)
         bcc_pkg::REG_SAMPLE_PERIOD: prdata = {16'd0, cfg_ff.sample_period_ticks};
         bcc_pkg::REG_GAP:           prdata = {16'd0, cfg_ff.gap_ticks};
         bcc_pkg::REG_LONG_PRESS:    prdata = {24'd0, cfg_ff.long_press_samples};
         default:                    prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/bcc_fsm.sv
// Gesture state machine with sample and gap counters.
`timescale 1ns / 1ps

module bcc_fsm #(
   parameter int TICK_WIDTH = bcc_pkg::TICK_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              beat,
   input  logic              level,
   input  bcc_pkg::cfg_type  cfg,
   output bcc_pkg::kind_type kind
);

   localparam int CMP_W = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;

   bcc_pkg::phase_type    phase_ff;
   bcc_pkg::phase_type    phase_in;
   logic [TICK_WIDTH-1:0] tick_ff;
   logic [TICK_WIDTH-1:0] tick_in;
   logic [TICK_WIDTH-1:0] tick_inc;
   logic [7:0]            samp_ff;
   logic [7:0]            samp_in;
   logic [7:0]            samp_inc;
   logic [15:0]           period_m1;
   logic                  tick_sat;
   logic                  period_end;
   logic                  gap_end;

   // Counter compares; a zero period acts as one
   assign tick_sat   = &tick_ff;
   assign period_m1  = (cfg.sample_period_ticks == 16'd0) ? 16'd0
                                                         : cfg.sample_period_ticks - 16'd1;
   assign period_end = (CMP_W'(tick_ff) >= CMP_W'(period_m1)) || tick_sat;
   assign gap_end    = (CMP_W'(tick_ff) >= CMP_W'(cfg.gap_ticks)) || tick_sat;
   assign tick_inc   = tick_sat ? tick_ff : tick_ff + TICK_WIDTH'(1);
   assign samp_inc   = (&samp_ff) ? samp_ff : samp_ff + 8'd1;

   // Next state and counters
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      samp_in  = samp_ff;
      case (phase_ff)
         bcc_pkg::PH_PRESS1, bcc_pkg::PH_PRESS2: begin
            if (period_end) begin
               samp_in = samp_inc;
               tick_in = '0;
               if (!level) begin
                  phase_in = (phase_ff == bcc_pkg::PH_PRESS1) ? bcc_pkg::PH_GAP1
                                                              : bcc_pkg::PH_GAP2;
               end
            end else begin
               tick_in = tick_inc;
            end
         end
         bcc_pkg::PH_GAP1: begin
            if (level) begin
               phase_in = bcc_pkg::PH_PRESS2;
               tick_in  = '0;
               samp_in  = '0;
            end else if (gap_end) begin
               phase_in = bcc_pkg::PH_IDLE;
               tick_in  = '0;
               samp_in  = '0;
            end else begin
               tick_in = tick_inc;
            end
         end
         bcc_pkg::PH_GAP2: begin
            if (level) begin
               phase_in = bcc_pkg::PH_HOLD;
               tick_in  = '0;
               samp_in  = '0;
            end else if (gap_end) begin
               phase_in = bcc_pkg::PH_IDLE;
               tick_in  = '0;
               samp_in  = '0;
            end else begin
               tick_in = tick_inc;
            end
         end
         bcc_pkg::PH_HOLD: begin
            if (!level) begin
               phase_in = bcc_pkg::PH_IDLE;
            end
         end
         default: begin
            tick_in  = '0;
            samp_in  = '0;
            phase_in = level ? bcc_pkg::PH_PRESS1 : bcc_pkg::PH_IDLE;
         end
      endcase
   end

   // Result of this beat
   always_comb begin
      kind = bcc_pkg::KIND_NONE;
      case (phase_ff)
         bcc_pkg::PH_GAP1: begin
            if (!level && gap_end) begin
               kind = (samp_ff <= cfg.long_press_samples) ? bcc_pkg::KIND_SINGLE
                                                          : bcc_pkg::KIND_LONG;
            end
         end
         bcc_pkg::PH_GAP2: begin
            if (level) begin
               kind = bcc_pkg::KIND_TRIPLE;
            end else if (gap_end) begin
               kind = bcc_pkg::KIND_DOUBLE;
            end
         end
         default: kind = bcc_pkg::KIND_NONE;
      endcase
   end

   // Advance on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bcc_pkg::PH_IDLE;
         tick_ff  <= '0;
         samp_ff  <= '0;
      end else if (beat) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         samp_ff  <= samp_in;
      end
   end

endmodule

FILE: rtl/core/bcc_out.sv
// Result register between the classifier and the response channel.
`timescale 1ns / 1ps

module bcc_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bcc_pkg::kind_type kind,
   output logic              beat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_click_kind
);

   logic              valid_ff;
   logic              valid_in;
   bcc_pkg::kind_type kind_ff;

   // Take a beat whenever the result slot is free or draining
   assign req_ready = !valid_ff || rsp_ready;
   assign beat      = req_valid && req_ready;
   assign valid_in  = beat || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the result with the beat
   always_ff @(posedge clock) begin
      if (beat) begin
         kind_ff <= kind;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_click_kind = kind_ff;

endmodule

FILE: rtl/core/button_multi_click_classifier.sv
// Top level of the button multi-click classifier.
`timescale 1ns / 1ps

// Takes one button level beat per tick and returns exactly one click_kind beat
// for each (0 none, 1 single, 2 long, 3 double, 4 triple). Every accepted beat
// is classified combinationally by the gesture state machine and lands in
// the result register on the same edge, so the result shows in the cycle after
// acceptance and a new beat can be taken every cycle; req_ready drops only
// while a finished result sits in the result register and rsp_ready is low.
// Registers (APB, word addresses 0x0, 0x4, 0x8): sample period ticks, gap
// ticks, long-press sample threshold; write them only while the block is idle.

module button_multi_click_classifier #(
   parameter int TICK_WIDTH = bcc_pkg::TICK_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_button_level,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_click_kind,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bcc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bcc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bcc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   bcc_pkg::cfg_type  cfg;
   bcc_pkg::kind_type kind;
   logic              beat;

   bcc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bcc_fsm #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_fsm (
      .clock (clock),
      .reset (reset),
      .beat  (beat),
      .level (req_button_level),
      .cfg   (cfg),
      .kind  (kind)
   );

   bcc_out u_out (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .kind           (kind),
      .beat           (beat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_click_kind (rsp_click_kind)
   );

endmodule

FILE: rtl/core/bcc_checker.sv
// Port-level checks of the classifier, bound to the top level.
`timescale 1ns / 1ps

module bcc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_button_level,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [2:0]                      rsp_click_kind,
   input logic                            psel,
   input logic                            penable,
   input logic                            pwrite,
   input logic [bcc_pkg::CSR_ADDR_W-1:0]  paddr,
   input logic [bcc_pkg::CSR_DATA_W-1:0]  pwdata,
   input logic [bcc_pkg::CSR_DATA_W-1:0]  prdata,
   input logic                            pready
);

   // Held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_click_kind))
      else $error("result changed while stalled");

   // Every accepted beat yields a result next cycle
   a_beat_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted beat gave no result");

   // An empty result slot never blocks the input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result slot");

   // No result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Results are legal click codes
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_click_kind <= 3'd4))
      else $error("illegal click code");

endmodule

bind button_multi_click_classifier bcc_checker u_bcc_checker (.*);

FILE: tb/sv/button_multi_click_classifier_tb.sv
// Self-checking testbench for the button multi-click classifier.
`timescale 1ns / 1ps

module button_multi_click_classifier_tb;

   localparam int TICK_W      = bcc_pkg::TICK_WIDTH_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;
   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_button_level;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_click_kind;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [bcc_pkg::CSR_ADDR_W-1:0] paddr;
   logic [bcc_pkg::CSR_DATA_W-1:0] pwdata;
   logic [bcc_pkg::CSR_DATA_W-1:0] prdata;
   logic        pready;

   // Gesture tracker state and its register copy
   bcc_pkg::phase_type gest_phase   = bcc_pkg::PH_IDLE;
   logic [TICK_W-1:0]  gest_ticks   = '0;
   logic [7:0]         gest_samples = '0;
   logic [15:0]        cfg_period   = bcc_pkg::SAMPLE_PERIOD_RST;
   logic [15:0]        cfg_gap      = bcc_pkg::GAP_RST;
   logic [7:0]         cfg_long     = bcc_pkg::LONG_PRESS_RST;

   bcc_pkg::kind_type expected_kinds[$];

   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int hold_off_left     = 0;
   int mismatches        = 0;
   int beats_sent        = 0;
   int beats_checked     = 0;
   int settings_used     = 0;
   int stalled_cycles    = 0;
   int kind_seen[5]      = '{default: 0};

   button_multi_click_classifier DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_button_level (req_button_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_click_kind   (rsp_click_kind),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Advance the gesture tracker by one tick and return the click it reports
   function automatic bcc_pkg::kind_type classify_tick(input logic level);
      logic [16:0]       period;
      bcc_pkg::kind_type kind;
      kind   = bcc_pkg::KIND_NONE;
      period = (cfg_period == 16'd0) ? 17'd1 : {1'b0, cfg_period};
      case (gest_phase)
         bcc_pkg::PH_PRESS1, bcc_pkg::PH_PRESS2: begin
            // Count a sample at the end of each period; a low level there ends the press
            if ({1'b0, gest_ticks} >= period - 17'd1 || gest_ticks == TICK_MAX) begin
               if (gest_samples != 8'hFF) gest_samples = gest_samples + 8'd1;
               gest_ticks = '0;
               if (!level) begin
                  gest_phase = (gest_phase == bcc_pkg::PH_PRESS1) ? bcc_pkg::PH_GAP1
                                                                  : bcc_pkg::PH_GAP2;
               end
            end else begin
               gest_ticks = gest_ticks + TICK_W'(1);
            end
         end
         bcc_pkg::PH_GAP1: begin
            if (level) begin
               gest_phase   = bcc_pkg::PH_PRESS2;
               gest_ticks   = '0;
               gest_samples = '0;
            end else if (gest_ticks >= cfg_gap || gest_ticks == TICK_MAX) begin
               kind         = (gest_samples <= cfg_long) ? bcc_pkg::KIND_SINGLE
                                                         : bcc_pkg::KIND_LONG;
               gest_phase   = bcc_pkg::PH_IDLE;
               gest_ticks   = '0;
               gest_samples = '0;
            end else begin
               gest_ticks = gest_ticks + TICK_W'(1);
            end
         end
         bcc_pkg::PH_GAP2: begin
            if (level) begin
               kind         = bcc_pkg::KIND_TRIPLE;
               gest_phase   = bcc_pkg::PH_HOLD;
               gest_ticks   = '0;
               gest_samples = '0;
            end else if (gest_ticks >= cfg_gap || gest_ticks == TICK_MAX) begin
               kind         = bcc_pkg::KIND_DOUBLE;
               gest_phase   = bcc_pkg::PH_IDLE;
               gest_ticks   = '0;
               gest_samples = '0;
            end else begin
               gest_ticks = gest_ticks + TICK_W'(1);
            end
         end
         bcc_pkg::PH_HOLD: begin
            // Ignore the rest of the third press until release
            if (!level) gest_phase = bcc_pkg::PH_IDLE;
         end
         default: begin
            gest_ticks   = '0;
            gest_samples = '0;
            gest_phase   = level ? bcc_pkg::PH_PRESS1 : bcc_pkg::PH_IDLE;
         end
      endcase
      return kind;
   endfunction

   task automatic log_mismatch(input string what, input int exp_val, input int act_val);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("[%0t] mismatch: %s expected %0d got %0d", $realtime, what, exp_val, act_val);
      end
   endtask

   // Send one button level beat, idling before it at random
   task automatic send_level(input logic level);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_valid        <= 1'b1;
      req_button_level <= level;
      do @(posedge clock); while (!req_ready);
      expected_kinds.push_back(classify_tick(level));
      beats_sent++;
   endtask

   // Drop valid and hold until every expected click has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_kinds.size() != 0);
   endtask

   // One APB transfer: setup phase, access phase, then a return to idle
   task automatic csr_access(input logic wr, input bcc_pkg::reg_index_type idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rdata   = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_reg(input bcc_pkg::reg_index_type idx, input logic [31:0] exp_val);
      logic [31:0] rdata;
      csr_access(1'b0, idx, '0, rdata);
      if (rdata !== exp_val) log_mismatch($sformatf("register %s", idx.name()), exp_val, rdata);
   endtask

   // Write all three registers while idle, read them back and track them
   task automatic set_config(input logic [15:0] period, input logic [15:0] gap,
                             input logic [7:0] long_th);
      logic [31:0] unused;
      wait_drained();
      repeat (2) @(posedge clock);
      csr_access(1'b1, bcc_pkg::REG_SAMPLE_PERIOD, {16'b0, period}, unused);
      csr_access(1'b1, bcc_pkg::REG_GAP, {16'b0, gap}, unused);
      csr_access(1'b1, bcc_pkg::REG_LONG_PRESS, {24'b0, long_th}, unused);
      check_reg(bcc_pkg::REG_SAMPLE_PERIOD, {16'b0, period});
      check_reg(bcc_pkg::REG_GAP, {16'b0, gap});
      check_reg(bcc_pkg::REG_LONG_PRESS, {24'b0, long_th});
      cfg_period = period;
      cfg_gap    = gap;
      cfg_long   = long_th;
      settings_used++;
   endtask

   task automatic send_pattern(input string pattern);
      for (int i = 0; i < pattern.len(); i++) send_level(pattern[i] == "1");
   endtask

   // One press-release gesture of 1 to 4 presses, or a burst of bouncing noise
   task automatic send_gesture();
      int presses;
      int unit_ticks;
      int held;
      int released;
      unit_ticks = (cfg_period == 16'd0) ? 1 : int'(cfg_period);
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(1, 12)) send_level(1'($urandom_range(0, 1)));
      end else begin
         presses = $urandom_range(1, 4);
         for (int i = 0; i < presses; i++) begin
            held = $urandom_range(1, unit_ticks * 7);
            repeat (held) send_level(1'b1);
            if (i == presses - 1) begin
               released = int'(cfg_gap) + unit_ticks + $urandom_range(2, 4);
            end else begin
               released = $urandom_range(1, int'(cfg_gap) + 1);
            end
            repeat (released) send_level(1'b0);
         end
      end
   endtask

   // ---------------- tests ----------------

   task automatic test_reset_defaults();
      check_reg(bcc_pkg::REG_SAMPLE_PERIOD, {16'b0, bcc_pkg::SAMPLE_PERIOD_RST});
      check_reg(bcc_pkg::REG_GAP, {16'b0, bcc_pkg::GAP_RST});
      check_reg(bcc_pkg::REG_LONG_PRESS, {24'b0, bcc_pkg::LONG_PRESS_RST});
      send_pattern("11000");
   endtask

   // Zero period, zero gap and zero long threshold: one short press reads as long
   task automatic test_zero_thresholds();
      set_config(16'd0, 16'd0, 8'd0);
      send_pattern("100");
   endtask

   task automatic test_single_press();
      set_config(16'd1, 16'd1, 8'd2);
      send_pattern("1000");
   endtask

   // A long second press still closes as a double
   task automatic test_long_second_press();
      send_pattern("10111000");
   endtask

   // Third press gives triple at once, then the held level is ignored
   task automatic test_triple_hold();
      send_pattern("1010110");
   endtask

   task automatic test_register_extremes();
      set_config(16'hFFFF, 16'hFFFF, 8'hFF);
      send_pattern("111000");
   endtask

   // Stall the receiver long enough to back up the input, then drain fully
   task automatic test_backpressure();
      sender_idle_pct = 0;
      set_config(16'd2, 16'd3, 8'd1);
      hold_off_left   = 150;
      repeat (40) send_level(1'($urandom_range(0, 1)));
      wait_drained();
   endtask

   task automatic test_random_gestures(input int send_pct, input int recv_pct, input int n_items);
      int stop_at;
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      repeat (2) begin
         set_config(16'($urandom_range(0, 5)), 16'($urandom_range(0, 8)),
                    8'($urandom_range(0, 6)));
         stop_at = beats_sent + n_items / 2;
         while (beats_sent < stop_at) send_gesture();
      end
   endtask

   // ---------------- result side ----------------

   // Check each click beat against the oldest prediction and pick the next ready
   always @(posedge clock) begin : rsp_check
      bcc_pkg::kind_type exp_kind;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_kinds.size() == 0) begin
            log_mismatch("unexpected click beat, click_kind", -1, rsp_click_kind);
         end else begin
            exp_kind = expected_kinds.pop_front();
            kind_seen[int'(exp_kind)]++;
            beats_checked++;
            if (rsp_click_kind !== exp_kind) begin
               log_mismatch($sformatf("beat %0d click_kind", beats_checked),
                            exp_kind, rsp_click_kind);
            end
         end
      end
      if (hold_off_left > 0) begin
         rsp_ready <= 1'b0;
         hold_off_left--;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // End the run if nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d clicks still due",
                  STALL_LIMIT, expected_kinds.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------- sequence ----------------

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_button_level <= 1'b0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct   = 30;
      receiver_idle_pct = 65;
      test_reset_defaults();
      test_zero_thresholds();
      test_single_press();
      test_long_second_press();
      test_triple_hold();
      test_register_extremes();
      test_backpressure();
      test_random_gestures(30, 65, 520);
      test_random_gestures(65, 30, 520);
      test_random_gestures(0, 0, 520);

      wait_drained();
      repeat (4) @(posedge clock);
      if (expected_kinds.size() != 0) log_mismatch("clicks left over", 0, expected_kinds.size());

      $display("sent %0d button beats over %0d register settings, %0d mismatches",
               beats_sent, settings_used, mismatches);
      $display("clicks seen: none %0d single %0d long %0d double %0d triple %0d",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
